/* rtl/core/text_console_cursor_engine_core_assert.svh */
// Assertion macros for the console cursor engine RTL.
`ifndef TEXT_CONSOLE_CURSOR_ENGINE_CORE_ASSERT_SVH
`define TEXT_CONSOLE_CURSOR_ENGINE_CORE_ASSERT_SVH

// Same-cycle implication, checked outside of reset.
`define TCCE_ASSERT_NOW(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cursor engine check failed");

// Next-cycle implication, checked outside of reset.
`define TCCE_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cursor engine check failed");

`endif

/* rtl/core/tcce_pkg.sv */
// Types and constants of the text console cursor engine.
package tcce_pkg;

   // Command selector codes.
   localparam logic [1:0] FUNC_PUT   = 2'd0;
   localparam logic [1:0] FUNC_SET   = 2'd1;
   localparam logic [1:0] FUNC_CLEAR = 2'd2;

   // Character codes with a meaning of their own.
   localparam logic [7:0] CHR_BS        = 8'd8;
   localparam logic [7:0] CHR_TAB       = 8'd9;
   localparam logic [7:0] CHR_LF        = 8'd10;
   localparam logic [7:0] CHR_CR        = 8'd13;
   localparam logic [7:0] CHR_PRINT_LO  = 8'd32;
   localparam logic [7:0] CHR_PRINT_END = 8'd127;

   // Configuration register indexes.
   localparam logic [1:0] CSR_TEXT_COLUMNS = 2'd0;
   localparam logic [1:0] CSR_TEXT_ROWS    = 2'd1;
   localparam logic [1:0] CSR_HW_SCROLL    = 2'd2;
   localparam logic [1:0] CSR_SCROLL_LIMIT = 2'd3;

   localparam logic [7:0] TEXT_COLUMNS_RESET = 8'd80;
   localparam logic [7:0] TEXT_ROWS_RESET    = 8'd30;

   typedef enum logic [2:0] {
      ACT_CURSOR      = 3'd0,
      ACT_GLYPH       = 3'd1,
      ACT_SOFT_SCROLL = 3'd2,
      ACT_WRAP_COPY   = 3'd3,
      ACT_HW_SCROLL   = 3'd4,
      ACT_CLEAR       = 3'd5
   } action_type;

   typedef struct packed {
      logic [1:0] func;
      logic [7:0] char_code;
      logic [7:0] target_row;
      logic [7:0] target_col;
   } cmd_type;

   typedef struct packed {
      logic [7:0]  text_columns;
      logic [7:0]  text_rows;
      logic        hw_scroll_enable;
      logic [15:0] scroll_limit;
   } cfg_type;

   typedef struct packed {
      logic [7:0]  row_pos;
      logic [7:0]  col_pos;
      logic [15:0] view_offset;
   } state_type;

   typedef struct packed {
      action_type  action;
      logic [7:0]  glyph;
      logic [7:0]  at_row;
      logic [7:0]  at_col;
      logic [15:0] offset_now;
   } event_type;

   // Up to three events of one command plus the cursor after the command.
   typedef struct packed {
      logic [1:0]      count;
      event_type [2:0] ev;
      logic [7:0]      final_row;
      logic [7:0]      final_col;
   } evlist_type;

endpackage

/* rtl/core/tcce_step.sv */
// Combinational command step: next cursor state and the list of events.
module tcce_step #(
   parameter int GLYPH_HEIGHT = 16
) (
   input  tcce_pkg::cmd_type    cmd,
   input  tcce_pkg::cfg_type    cfg,
   input  tcce_pkg::state_type  cur,
   output tcce_pkg::state_type  nxt,
   output tcce_pkg::evlist_type evl
);

   localparam logic [16:0] GH_WIDE = 17'(GLYPH_HEIGHT);
   localparam logic [15:0] GH      = 16'(GLYPH_HEIGHT);

   function automatic tcce_pkg::event_type make_event(
      input tcce_pkg::action_type act,
      input logic [7:0]           g,
      input logic [7:0]           r,
      input logic [7:0]           c,
      input logic [15:0]          off
   );
      tcce_pkg::event_type e;
      e.action     = act;
      e.glyph      = g;
      e.at_row     = r;
      e.at_col     = c;
      e.offset_now = off;
      return e;
   endfunction

   logic [8:0]  tab_t;
   logic [8:0]  inc_t;
   logic [8:0]  row_inc;
   logic [16:0] off_sum;
   logic        wrap;
   logic [15:0] hw_off;

   assign tab_t   = ({1'b0, cur.col_pos} + 9'd8) & ~9'd7;
   assign inc_t   = {1'b0, cur.col_pos} + 9'd1;
   assign row_inc = {1'b0, cur.row_pos} + 9'd1;
   assign off_sum = {1'b0, cur.view_offset} + GH_WIDE;
   assign wrap    = off_sum > {1'b0, cfg.scroll_limit};
   assign hw_off  = (wrap ? 16'd0 : cur.view_offset) + GH;

   always_comb begin
      logic       nl;
      logic       pr;
      logic       clr;
      logic       scroll;
      logic [1:0] n;
      nl     = 1'b0;
      pr     = 1'b0;
      clr    = 1'b0;
      scroll = 1'b0;
      n      = 2'd0;
      nxt    = cur;

      unique case (cmd.func)
         tcce_pkg::FUNC_PUT: begin
            if (cmd.char_code == tcce_pkg::CHR_LF) begin
               nl = 1'b1;
            end else if (cmd.char_code == tcce_pkg::CHR_CR) begin
               nxt.col_pos = 8'd0;
            end else if (cmd.char_code == tcce_pkg::CHR_TAB) begin
               if (tab_t >= {1'b0, cfg.text_columns}) nl = 1'b1;
               else nxt.col_pos = tab_t[7:0];
            end else if (cmd.char_code == tcce_pkg::CHR_BS) begin
               if (cur.col_pos != 8'd0) nxt.col_pos = cur.col_pos - 8'd1;
            end else if (cmd.char_code >= tcce_pkg::CHR_PRINT_LO &&
                         cmd.char_code < tcce_pkg::CHR_PRINT_END) begin
               pr = 1'b1;
               if (inc_t >= {1'b0, cfg.text_columns}) nl = 1'b1;
               else nxt.col_pos = inc_t[7:0];
            end
         end
         tcce_pkg::FUNC_SET: begin
            if (cmd.target_row < cfg.text_rows)    nxt.row_pos = cmd.target_row;
            if (cmd.target_col < cfg.text_columns) nxt.col_pos = cmd.target_col;
         end
         tcce_pkg::FUNC_CLEAR: begin
            clr         = 1'b1;
            nxt.row_pos = 8'd0;
            nxt.col_pos = 8'd0;
            if (cfg.hw_scroll_enable) nxt.view_offset = 16'd0;
         end
         default: begin
         end
      endcase

      // Newline: column 0 and next row, scrolling when the bottom is passed.
      if (nl) begin
         nxt.col_pos = 8'd0;
         if (row_inc >= {1'b0, cfg.text_rows}) begin
            scroll      = 1'b1;
            nxt.row_pos = (cfg.text_rows == 8'd0) ? 8'd0 : cfg.text_rows - 8'd1;
         end else begin
            nxt.row_pos = row_inc[7:0];
         end
      end
      if (scroll && cfg.hw_scroll_enable) nxt.view_offset = hw_off;

      evl    = '0;
      if (pr) begin
         evl.ev[n] = make_event(tcce_pkg::ACT_GLYPH, cmd.char_code, cur.row_pos,
                                cur.col_pos, cur.view_offset);
         n = n + 2'd1;
      end
      if (scroll && !cfg.hw_scroll_enable) begin
         evl.ev[n] = make_event(tcce_pkg::ACT_SOFT_SCROLL, 8'd0, 8'd0, 8'd0,
                                cur.view_offset);
         n = n + 2'd1;
      end
      if (scroll && cfg.hw_scroll_enable && wrap) begin
         evl.ev[n] = make_event(tcce_pkg::ACT_WRAP_COPY, 8'd0, 8'd0, 8'd0, 16'd0);
         n = n + 2'd1;
      end
      if (scroll && cfg.hw_scroll_enable) begin
         evl.ev[n] = make_event(tcce_pkg::ACT_HW_SCROLL, 8'd0, 8'd0, 8'd0, hw_off);
         n = n + 2'd1;
      end
      if (clr) begin
         evl.ev[n] = make_event(tcce_pkg::ACT_CLEAR, 8'd0, 8'd0, 8'd0,
                                nxt.view_offset);
         n = n + 2'd1;
      end
      if (n == 2'd0) begin
         evl.ev[0] = make_event(tcce_pkg::ACT_CURSOR, 8'd0, 8'd0, 8'd0,
                                cur.view_offset);
         n = 2'd1;
      end
      evl.count     = n;
      evl.final_row = nxt.row_pos;
      evl.final_col = nxt.col_pos;
   end

endmodule

/* rtl/core/tcce_evbuf.sv */
// Result register holding one command's events and handing them out in order.
module tcce_evbuf (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  tcce_pkg::evlist_type list_in,
   input  logic                 out_ready,
   output logic                 out_valid,
   output tcce_pkg::event_type  out_ev,
   output logic [7:0]           out_row,
   output logic [7:0]           out_col,
   output logic                 out_last,
   output logic                 free
);

   tcce_pkg::evlist_type list_ff;
   logic                 valid_ff;
   logic [1:0]           idx_ff;
   logic                 pop;

   assign out_valid = valid_ff;
   assign out_ev    = list_ff.ev[idx_ff];
   assign out_row   = list_ff.final_row;
   assign out_col   = list_ff.final_col;
   assign out_last  = idx_ff == (list_ff.count - 2'd1);
   assign pop       = valid_ff && out_ready;
   assign free      = !valid_ff || (pop && out_last);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 2'd0;
      end else if (load) begin
         valid_ff <= 1'b1;
         idx_ff   <= 2'd0;
      end else if (pop && out_last) begin
         valid_ff <= 1'b0;
      end else if (pop) begin
         idx_ff <= idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (load) list_ff <= list_in;
   end

endmodule

/* rtl/core/text_console_cursor_engine_core.sv */
// Top level of the text console cursor engine: ports, registers and control.
//
// The engine takes one console command per beat (put character, set cursor,
// clear screen) and returns one to three result beats describing what the
// display must do: draw a glyph, scroll in software, copy back and wrap the
// hardware scroll offset, advance the hardware offset, clear, or only move
// the cursor. Every result beat carries the cursor position after the whole
// command and the scroll offset right after its own action; tlast marks the
// final beat of a command. A command first lands in an input register, is
// evaluated by one pass of short logic against the cursor state, and its
// results land in a result register as soon as that register is free, from
// where the result beats are offered. A new command is taken in every cycle
// as long as each yields a single result and the receiver takes each beat;
// a command with n results holds the result register for n output beats.
// Reset clears the cursor and the offset and loads the register defaults
// (80 columns, 30 rows, software scrolling, scroll limit 0). Configuration
// is taken in any cycle and must only be written while no command is in
// flight.
module text_console_cursor_engine_core #(
   parameter int GLYPH_HEIGHT = 16
) (
   input  logic        clock,
   input  logic        reset,
   // Command channel.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // char_code[7:0], target_row[15:8], target_col[23:16]
   input  logic [1:0]  req_tuser,   // func[1:0]
   // Result channel.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // glyph[7:0], at_row[15:8], at_col[23:16],
                                    // offset_now[39:24], cursor_row_now[47:40],
                                    // cursor_col_now[55:48]
   output logic [2:0]  rsp_tuser,   // action[2:0]
   output logic        rsp_tlast,
   // Configuration write channel.
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);

   `include "text_console_cursor_engine_core_assert.svh"

   tcce_pkg::cfg_type    cfg_ff;
   tcce_pkg::state_type  state_ff;
   tcce_pkg::state_type  state_in;
   tcce_pkg::cmd_type    cmd_ff;
   logic                 cmd_valid_ff;
   tcce_pkg::evlist_type evl;
   tcce_pkg::event_type  out_ev;
   logic [7:0]           out_row;
   logic [7:0]           out_col;
   logic                 buf_free;
   logic                 load;
   logic                 rsp_is_cursor;
   logic                 rsp_is_wrap;

   // The held command moves into the result register as soon as that register
   // is empty or hands out its final beat in this cycle.
   assign load       = cmd_valid_ff && buf_free;
   assign req_tready = !cmd_valid_ff || load;
   assign csr_ready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_valid_ff <= 1'b0;
      end else if (req_tready) begin
         cmd_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         cmd_ff.func       <= req_tuser;
         cmd_ff.char_code  <= req_tdata[7:0];
         cmd_ff.target_row <= req_tdata[15:8];
         cmd_ff.target_col <= req_tdata[23:16];
      end
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.text_columns     <= tcce_pkg::TEXT_COLUMNS_RESET;
         cfg_ff.text_rows        <= tcce_pkg::TEXT_ROWS_RESET;
         cfg_ff.hw_scroll_enable <= 1'b0;
         cfg_ff.scroll_limit     <= 16'd0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            tcce_pkg::CSR_TEXT_COLUMNS: cfg_ff.text_columns     <= csr_data[7:0];
            tcce_pkg::CSR_TEXT_ROWS:    cfg_ff.text_rows        <= csr_data[7:0];
            tcce_pkg::CSR_HW_SCROLL:    cfg_ff.hw_scroll_enable <= csr_data[0];
            tcce_pkg::CSR_SCROLL_LIMIT: cfg_ff.scroll_limit     <= csr_data;
            default: begin
            end
         endcase
      end
   end

   // Cursor and offset advance when a command is evaluated.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (load) begin
         state_ff <= state_in;
      end
   end

   tcce_step #(
      .GLYPH_HEIGHT(GLYPH_HEIGHT)
   ) u_step (
      .cmd (cmd_ff),
      .cfg (cfg_ff),
      .cur (state_ff),
      .nxt (state_in),
      .evl (evl)
   );

   tcce_evbuf u_evbuf (
      .clock     (clock),
      .reset     (reset),
      .load      (load),
      .list_in   (evl),
      .out_ready (rsp_tready),
      .out_valid (rsp_tvalid),
      .out_ev    (out_ev),
      .out_row   (out_row),
      .out_col   (out_col),
      .out_last  (rsp_tlast),
      .free      (buf_free)
   );

   assign rsp_tuser = out_ev.action;
   assign rsp_tdata = {out_col, out_row, out_ev.offset_now,
                       out_ev.at_col, out_ev.at_row, out_ev.glyph};

   assign rsp_is_cursor = rsp_tvalid && rsp_tuser == tcce_pkg::ACT_CURSOR;
   assign rsp_is_wrap   = rsp_tvalid && rsp_tuser == tcce_pkg::ACT_WRAP_COPY;

   // A cursor-only result is always the single result of its command.
   `TCCE_ASSERT_NOW(a_cursor_single, clock, reset, rsp_is_cursor, rsp_tlast)
   // A wrap copy reports offset zero and is always followed by a hardware scroll.
   `TCCE_ASSERT_NOW(a_wrap_copy, clock, reset, rsp_is_wrap, rsp_tdata[39:24] == 16'd0 && !rsp_tlast)
   // An evaluated command shows a result in the next cycle.
   `TCCE_ASSERT_NEXT(a_load_shows, clock, reset, load, rsp_tvalid)

endmodule

/* tb/text_console_cursor_engine_core_test.sv */
// Self-checking testbench for the text console cursor engine core.
module text_console_cursor_engine_core_test;
   timeunit 1ns;
   timeprecision 1ps;

   // The glyph height must match the instance parameter below.
   localparam int GLYPH_H = 16;
   // The selector value that the block must ignore.
   localparam logic [1:0] FUNC_UNUSED = 2'd3;
   // Cycles of quiet after the last result before config writes or the end.
   localparam int IDLE_PAUSE = 8;
   // Cycles without any handshake after which the run is declared hung.
   localparam int QUIET_LIMIT = 3000;
   // Length of the one long receiver hold-off that backs up the pipeline.
   localparam int LONG_HOLD = 80;

   // One expected result beat: the action itself plus the cursor after the
   // whole command and the end-of-command marker.
   typedef struct packed {
      tcce_pkg::event_type ev;
      logic [7:0]          cursor_row_now;
      logic [7:0]          cursor_col_now;
      logic                last;
   } result_beat_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;   // char_code[7:0], target_row[15:8], target_col[23:16]
   logic [1:0]  req_tuser = '0;   // func[1:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [55:0] rsp_tdata;        // glyph[7:0], at_row[15:8], at_col[23:16],
                                  // offset_now[39:24], cursor_row_now[47:40],
                                  // cursor_col_now[55:48]
   logic [2:0]  rsp_tuser;        // action[2:0]
   logic        rsp_tlast;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [15:0] csr_data = '0;

   // Shadow copy of the console state and of the configuration registers.
   tcce_pkg::cfg_type cfg;
   logic [7:0]        cur_row;
   logic [7:0]        cur_col;
   logic [15:0]       scroll_off;

   // Commands waiting to be sent; the head stays queued until it is accepted.
   tcce_pkg::cmd_type   pending_cmds[$];
   // Actions collected while one command is evaluated.
   tcce_pkg::event_type step_events[$];
   // Result beats that the block still owes us, oldest first.
   result_beat_type     expected_results[$];

   // Idle behavior per phase, set by the sequencer and read by driver/monitor.
   bit send_idle = 1'b1;
   bit recv_idle = 1'b1;
   bit pressure_armed = 1'b0;

   int send_gap = 0;
   int recv_gap = 0;
   int hold_cycles = 0;
   bit pressure_done = 1'b0;
   bit offer = 1'b0;
   bit take;
   int quiet_cycles = 0;
   int error_count = 0;
   result_beat_type head;

   text_console_cursor_engine_core #(
      .GLYPH_HEIGHT(GLYPH_H)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #10 clock = ~clock;

   // ------------------------------------------------------------------------
   // Console predictor
   // ------------------------------------------------------------------------

   // Records one action; it carries the offset as it stands at this moment.
   task automatic note_action(input tcce_pkg::action_type act, input logic [7:0] g,
                              input logic [7:0] r, input logic [7:0] c);
      tcce_pkg::event_type e;
      e.action     = act;
      e.glyph      = g;
      e.at_row     = r;
      e.at_col     = c;
      e.offset_now = scroll_off;
      step_events.push_back(e);
   endtask

   // Software scrolling only reports a screen move. Hardware scrolling first
   // wraps the offset with a copy-back when one more glyph height would pass
   // the limit, then always advances the offset by one glyph height.
   task automatic scroll_view();
      if (!cfg.hw_scroll_enable) begin
         note_action(tcce_pkg::ACT_SOFT_SCROLL, 8'd0, 8'd0, 8'd0);
      end else begin
         if (int'(scroll_off) + GLYPH_H > int'(cfg.scroll_limit)) begin
            scroll_off = '0;
            note_action(tcce_pkg::ACT_WRAP_COPY, 8'd0, 8'd0, 8'd0);
         end
         scroll_off = scroll_off + 16'(GLYPH_H);
         note_action(tcce_pkg::ACT_HW_SCROLL, 8'd0, 8'd0, 8'd0);
      end
   endtask

   // The row compare is made wide so that a cursor left beyond a shrunk
   // screen, or a screen of zero rows, still scrolls and lands on the last row.
   task automatic new_line();
      cur_col = '0;
      if (int'(cur_row) + 1 >= int'(cfg.text_rows)) begin
         scroll_view();
         cur_row = (cfg.text_rows == 8'd0) ? 8'd0 : cfg.text_rows - 8'd1;
      end else begin
         cur_row = cur_row + 8'd1;
      end
   endtask

   task automatic put_character(input logic [7:0] ch);
      int t;
      if (ch == tcce_pkg::CHR_LF) begin
         new_line();
      end else if (ch == tcce_pkg::CHR_CR) begin
         cur_col = '0;
      end else if (ch == tcce_pkg::CHR_TAB) begin
         // Next multiple of eight, computed wide: at column 248 and beyond it
         // reaches 256 and must not fold back to zero.
         t = (int'(cur_col) + 8) & ~7;
         if (t >= int'(cfg.text_columns)) begin
            new_line();
         end else begin
            cur_col = 8'(t);
         end
      end else if (ch == tcce_pkg::CHR_BS) begin
         if (cur_col != 8'd0) begin
            cur_col = cur_col - 8'd1;
         end
      end else if (ch >= tcce_pkg::CHR_PRINT_LO && ch < tcce_pkg::CHR_PRINT_END) begin
         note_action(tcce_pkg::ACT_GLYPH, ch, cur_row, cur_col);
         t = int'(cur_col) + 1;
         if (t >= int'(cfg.text_columns)) begin
            new_line();
         end else begin
            cur_col = 8'(t);
         end
      end
   endtask

   // Evaluates one accepted command and queues the result beats it causes.
   task automatic advance_console(input tcce_pkg::cmd_type cmd);
      result_beat_type beat;
      step_events.delete();
      case (cmd.func)
         tcce_pkg::FUNC_PUT: begin
            put_character(cmd.char_code);
         end
         tcce_pkg::FUNC_SET: begin
            // Row and column are each ignored on their own when out of range.
            if (cmd.target_row < cfg.text_rows) begin
               cur_row = cmd.target_row;
            end
            if (cmd.target_col < cfg.text_columns) begin
               cur_col = cmd.target_col;
            end
         end
         tcce_pkg::FUNC_CLEAR: begin
            // The offset is only reset when hardware scrolling is in use.
            if (cfg.hw_scroll_enable) begin
               scroll_off = '0;
            end
            cur_row = '0;
            cur_col = '0;
            note_action(tcce_pkg::ACT_CLEAR, 8'd0, 8'd0, 8'd0);
         end
         default: begin
         end
      endcase
      // A command that draws and scrolls nothing still yields one beat.
      if (step_events.size() == 0) begin
         note_action(tcce_pkg::ACT_CURSOR, 8'd0, 8'd0, 8'd0);
      end
      foreach (step_events[i]) begin
         beat.ev             = step_events[i];
         beat.cursor_row_now = cur_row;
         beat.cursor_col_now = cur_col;
         beat.last           = (i == step_events.size() - 1);
         expected_results.push_back(beat);
      end
   endtask

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------

   task automatic queue_cmd(input logic [1:0] f, input logic [7:0] ch,
                            input logic [7:0] r, input logic [7:0] c);
      tcce_pkg::cmd_type cmd;
      cmd.func       = f;
      cmd.char_code  = ch;
      cmd.target_row = r;
      cmd.target_col = c;
      pending_cmds.push_back(cmd);
   endtask

   // Mostly printable text and control bytes, which is what drives the cursor
   // through wraps and scrolls; set-cursor beats mostly land on screen so the
   // cursor visits the edges; the rest is raw noise, clears and the unused
   // selector.
   function automatic tcce_pkg::cmd_type random_command();
      tcce_pkg::cmd_type c;
      int pick;
      pick         = $urandom_range(0, 99);
      c.func       = tcce_pkg::FUNC_PUT;
      c.char_code  = 8'($urandom);
      c.target_row = 8'($urandom);
      c.target_col = 8'($urandom);
      if (pick < 55) begin
         c.char_code = 8'($urandom_range(32, 126));
      end else if (pick < 70) begin
         case ($urandom_range(0, 3))
            0:       c.char_code = tcce_pkg::CHR_LF;
            1:       c.char_code = tcce_pkg::CHR_CR;
            2:       c.char_code = tcce_pkg::CHR_TAB;
            default: c.char_code = tcce_pkg::CHR_BS;
         endcase
      end else if (pick < 75) begin
         // Any byte at all, including the ignored ones.
      end else if (pick < 88) begin
         c.func = tcce_pkg::FUNC_SET;
         if (cfg.text_rows != 8'd0) begin
            c.target_row = 8'($urandom_range(0, int'(cfg.text_rows) - 1));
         end
         if (cfg.text_columns != 8'd0) begin
            c.target_col = 8'($urandom_range(0, int'(cfg.text_columns) - 1));
         end
      end else if (pick < 94) begin
         c.func = tcce_pkg::FUNC_SET;
      end else if (pick < 97) begin
         c.func = tcce_pkg::FUNC_CLEAR;
      end else begin
         c.func = FUNC_UNUSED;
      end
      return c;
   endfunction

   task automatic queue_random(input int count);
      repeat (count) pending_cmds.push_back(random_command());
   endtask

   // Writes one register and mirrors it into the shadow configuration. The
   // valid stays high across back-to-back writes; the caller lowers it.
   task automatic write_register(input logic [1:0] idx, input logic [15:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         tcce_pkg::CSR_TEXT_COLUMNS: cfg.text_columns     = value[7:0];
         tcce_pkg::CSR_TEXT_ROWS:    cfg.text_rows        = value[7:0];
         tcce_pkg::CSR_HW_SCROLL:    cfg.hw_scroll_enable = value[0];
         tcce_pkg::CSR_SCROLL_LIMIT: cfg.scroll_limit     = value;
         default: begin
         end
      endcase
   endtask

   task automatic load_config(input logic [7:0] cols, input logic [7:0] rows,
                              input logic hw, input logic [15:0] limit);
      write_register(tcce_pkg::CSR_TEXT_COLUMNS, {8'd0, cols});
      write_register(tcce_pkg::CSR_TEXT_ROWS, {8'd0, rows});
      write_register(tcce_pkg::CSR_HW_SCROLL, {15'd0, hw});
      write_register(tcce_pkg::CSR_SCROLL_LIMIT, limit);
      csr_valid <= 1'b0;
   endtask

   // Waits until every queued command has gone in and every result has come
   // out, then lets the pipeline settle before anything else happens.
   task automatic wait_drained();
      while (pending_cmds.size() != 0 || expected_results.size() != 0) begin
         @(posedge clock);
      end
      repeat (IDLE_PAUSE) @(posedge clock);
   endtask

   task automatic compare_field(input string name, input logic [15:0] want,
                                input logic [15:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0d, actual %0d", name, want, got);
         error_count++;
      end
   endtask

   // ------------------------------------------------------------------------
   // Command driver: offers the head of the pending queue, predicts on
   // acceptance, then idles for a drawn number of cycles. With no idle drawn
   // the valid simply stays high into the next command.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         offer = 1'b0;
         send_gap = 0;
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            advance_console(pending_cmds.pop_front());
            offer = 1'b0;
            send_gap = send_idle ? $urandom_range(0, 12) : 0;
         end
         if (!offer) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (pending_cmds.size() != 0) begin
               offer = 1'b1;
            end
         end
         req_tvalid <= offer;
         if (offer) begin
            req_tdata <= {pending_cmds[0].target_col, pending_cmds[0].target_row,
                          pending_cmds[0].char_code};
            req_tuser <= pending_cmds[0].func;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Result monitor: checks each accepted beat against the oldest expected
   // one and draws its own stall after every beat. Once armed, it holds off
   // for a long stretch so the block backs up and stalls its input.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         recv_gap = 0;
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_results.size() == 0) begin
               $error("result beat with nothing expected: action %0d", rsp_tuser);
               error_count++;
            end else begin
               head = expected_results.pop_front();
               compare_field("action", head.ev.action, rsp_tuser);
               compare_field("glyph", head.ev.glyph, rsp_tdata[7:0]);
               compare_field("at_row", head.ev.at_row, rsp_tdata[15:8]);
               compare_field("at_col", head.ev.at_col, rsp_tdata[23:16]);
               compare_field("offset_now", head.ev.offset_now, rsp_tdata[39:24]);
               compare_field("cursor_row_now", head.cursor_row_now, rsp_tdata[47:40]);
               compare_field("cursor_col_now", head.cursor_col_now, rsp_tdata[55:48]);
               compare_field("last", head.last, rsp_tlast);
            end
            recv_gap = recv_idle ? $urandom_range(0, 12) : 0;
         end
         if (pressure_armed && !pressure_done) begin
            pressure_done = 1'b1;
            hold_cycles = LONG_HOLD;
         end
         if (hold_cycles > 0) begin
            hold_cycles--;
            take = 1'b0;
         end else if (recv_gap > 0) begin
            recv_gap--;
            take = 1'b0;
         end else begin
            take = 1'b1;
         end
         rsp_tready <= take;
      end
   end

   // Watchdog: any handshake on any channel counts as progress.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("[text_console_cursor_engine_core] ERROR");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Sequencer: reset, directed commands at the reset configuration, then a
   // series of configurations, each followed by random text.
   // ------------------------------------------------------------------------
   initial begin
      cfg.text_columns     = tcce_pkg::TEXT_COLUMNS_RESET;
      cfg.text_rows        = tcce_pkg::TEXT_ROWS_RESET;
      cfg.hw_scroll_enable = 1'b0;
      cfg.scroll_limit     = '0;
      cur_row    = '0;
      cur_col    = '0;
      scroll_off = '0;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Reset screen of 80 by 30 with software scrolling.
      queue_cmd(tcce_pkg::FUNC_PUT, 8'h41, 8'd0, 8'd0);          // plain glyph at home
      queue_cmd(tcce_pkg::FUNC_PUT, tcce_pkg::CHR_PRINT_LO, 8'd0, 8'd0);   // lowest printable
      queue_cmd(tcce_pkg::FUNC_PUT, 8'd126, 8'd0, 8'd0);         // highest printable
      queue_cmd(tcce_pkg::FUNC_PUT, tcce_pkg::CHR_PRINT_END, 8'd0, 8'd0);  // first past it
      queue_cmd(tcce_pkg::FUNC_PUT, 8'd0, 8'd0, 8'd0);
      queue_cmd(tcce_pkg::FUNC_PUT, 8'd255, 8'd255, 8'd255);
      queue_cmd(tcce_pkg::FUNC_PUT, 8'd31, 8'd0, 8'd0);
      queue_cmd(tcce_pkg::FUNC_PUT, tcce_pkg::CHR_TAB, 8'd0, 8'd0);
      queue_cmd(tcce_pkg::FUNC_PUT, tcce_pkg::CHR_BS, 8'd0, 8'd0);
      queue_cmd(tcce_pkg::FUNC_PUT, tcce_pkg::CHR_CR, 8'd0, 8'd0);
      queue_cmd(tcce_pkg::FUNC_PUT, tcce_pkg::CHR_BS, 8'd0, 8'd0);  // backspace at column 0
      queue_cmd(tcce_pkg::FUNC_PUT, tcce_pkg::CHR_LF, 8'd0, 8'd0);
      queue_cmd(tcce_pkg::FUNC_SET, 8'd0, 8'd29, 8'd79);         // bottom right corner
      queue_cmd(tcce_pkg::FUNC_PUT, 8'h5A, 8'd0, 8'd0);          // glyph, wrap and scroll
      queue_cmd(tcce_pkg::FUNC_SET, 8'd0, 8'd30, 8'd80);         // both just out of range
      queue_cmd(tcce_pkg::FUNC_SET, 8'd0, 8'd255, 8'd255);
      queue_cmd(tcce_pkg::FUNC_SET, 8'd0, 8'd5, 8'd200);         // only the row lands
      queue_cmd(tcce_pkg::FUNC_SET, 8'd0, 8'd200, 8'd72);        // only the column lands
      queue_cmd(tcce_pkg::FUNC_PUT, tcce_pkg::CHR_TAB, 8'd0, 8'd0); // tab reaching the edge
      queue_cmd(tcce_pkg::FUNC_SET, 8'd0, 8'd29, 8'd3);
      queue_cmd(tcce_pkg::FUNC_PUT, tcce_pkg::CHR_LF, 8'd0, 8'd0);  // newline on last row
      queue_cmd(FUNC_UNUSED, 8'd255, 8'd255, 8'd255);
      queue_cmd(tcce_pkg::FUNC_CLEAR, 8'd0, 8'd0, 8'd0);
      wait_drained();

      // Tiny screen with hardware scrolling: frequent wraps of the offset.
      load_config(8'd10, 8'd3, 1'b1, 16'd48);
      queue_cmd(tcce_pkg::FUNC_SET, 8'd0, 8'd2, 8'd9);
      queue_cmd(tcce_pkg::FUNC_PUT, 8'h78, 8'd0, 8'd0);
      queue_random(18);
      wait_drained();

      // Largest screen, software scrolling, offset left nonzero from above;
      // a clear here must keep it. The tab from column 248 only crosses the
      // edge when the sum is kept wider than eight bits.
      send_idle = 1'b0;
      recv_idle = 1'b0;
      load_config(8'd255, 8'd255, 1'b0, 16'hFFFF);
      queue_cmd(tcce_pkg::FUNC_CLEAR, 8'd0, 8'd0, 8'd0);
      queue_cmd(tcce_pkg::FUNC_SET, 8'd0, 8'd254, 8'd248);
      queue_cmd(tcce_pkg::FUNC_PUT, tcce_pkg::CHR_TAB, 8'd0, 8'd0);
      queue_cmd(tcce_pkg::FUNC_SET, 8'd0, 8'd254, 8'd254);
      queue_cmd(tcce_pkg::FUNC_PUT, 8'h71, 8'd0, 8'd0);
      queue_random(18);
      queue_cmd(tcce_pkg::FUNC_SET, 8'd0, 8'd200, 8'd200);
      wait_drained();

      // Shrink the screen under a far-out cursor and flood the block while
      // the receiver holds off.
      load_config(8'd8, 8'd4, 1'b1, 16'd1000);
      pressure_armed = 1'b1;
      queue_cmd(tcce_pkg::FUNC_PUT, tcce_pkg::CHR_BS, 8'd0, 8'd0);
      queue_cmd(tcce_pkg::FUNC_PUT, 8'h61, 8'd0, 8'd0);
      queue_random(20);
      wait_drained();

      // One cell and a zero limit: every glyph gives three result beats.
      send_idle = 1'b1;
      recv_idle = 1'b1;
      load_config(8'd1, 8'd1, 1'b1, 16'd0);
      queue_random(18);
      wait_drained();

      // Degenerate screen of zero rows and columns.
      send_idle = 1'b0;
      load_config(8'd0, 8'd0, 1'b1, 16'd16);
      queue_random(15);
      wait_drained();

      if (error_count == 0) begin
         $display("[text_console_cursor_engine_core] OK");
      end else begin
         $display("[text_console_cursor_engine_core] ERROR");
      end
      $finish;
   end

endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/tcce_pkg.sv
rtl/core/tcce_step.sv
rtl/core/tcce_evbuf.sv
rtl/core/text_console_cursor_engine_core.sv
tb/text_console_cursor_engine_core_test.sv
